// ----- rtl/bdcb_pkg.sv -----
// Shared types, codes and constants for the batched delivery circuit breaker.
`timescale 1ns / 1ps

package bdcb_pkg;

  localparam int DELIVERY_SLOTS_DEF = 8;
  localparam int QUEUE_MAX_DEF      = 1024;

  localparam int CNT_W   = 11;
  localparam int TIMER_W = 27;
  localparam int CFG_W   = 20;
  localparam int IDX_W   = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_BATCH_SIZE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_QUEUE_LIMIT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_BATCH_DELAY  = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_ATTEMPTS = 3'd3;
  localparam logic [IDX_W-1:0] REG_RETRY_BASE   = 3'd4;
  localparam logic [IDX_W-1:0] REG_FAIL_THRESH  = 3'd5;
  localparam logic [IDX_W-1:0] REG_COOLDOWN     = 3'd6;

  localparam logic [10:0] BATCH_SIZE_RST   = 11'd10;
  localparam logic [10:0] QUEUE_LIMIT_RST  = 11'd1024;
  localparam logic [15:0] BATCH_DELAY_RST  = 16'd100;
  localparam logic [3:0]  MAX_ATTEMPTS_RST = 4'd3;
  localparam logic [11:0] RETRY_BASE_RST   = 12'd100;
  localparam logic [7:0]  FAIL_THRESH_RST  = 8'd5;
  localparam logic [19:0] COOLDOWN_RST     = 20'd30000;

  // commands
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_CAPTURE = 2'd1;
  localparam logic [1:0] CMD_FLUSH   = 2'd2;
  localparam logic [1:0] CMD_OUTCOME = 2'd3;

  // result kinds
  localparam logic [3:0] KIND_QUEUED       = 4'd0;
  localparam logic [3:0] KIND_DROP_FULL    = 4'd1;
  localparam logic [3:0] KIND_SEND         = 4'd2;
  localparam logic [3:0] KIND_DROP_CIRCUIT = 4'd3;
  localparam logic [3:0] KIND_RESEND       = 4'd4;
  localparam logic [3:0] KIND_GAVE_UP      = 4'd5;
  localparam logic [3:0] KIND_SUCCEEDED    = 4'd6;
  localparam logic [3:0] KIND_NO_SLOT      = 4'd7;
  localparam logic [3:0] KIND_RETRY_SCHED  = 4'd8;

  // circuit modes
  localparam logic [1:0] MODE_CLOSED    = 2'd0;
  localparam logic [1:0] MODE_OPEN      = 2'd1;
  localparam logic [1:0] MODE_HALF_OPEN = 2'd2;

  typedef struct packed {
    logic [3:0]       kind;
    logic [2:0]       slot;
    logic [CNT_W-1:0] count;
    logic [3:0]       attempt;
    logic [CNT_W-1:0] depth;
    logic [1:0]       mode;
  } result_t;

  // slot memory entry; free/busy lives in flops beside the memory
  typedef struct packed {
    logic               retry;
    logic [3:0]         attempt;
    logic [CNT_W-1:0]   count;
    logic [TIMER_W-1:0] timer;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

// ----- rtl/bdcb_slot_mem.sv -----
// Delivery slot table: one write port, one registered read port.
`timescale 1ns / 1ps

module bdcb_slot_mem
  import bdcb_pkg::*;
#(
  parameter int SLOTS = DELIVERY_SLOTS_DEF,
  parameter int AW    = 3
) (
  input  logic               clk,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [ENTRY_W-1:0] wdata,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [SLOTS];
  logic [ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/bdcb_out_stage.sv -----
// Result hold stage and output register; marks the last word of each item.
`timescale 1ns / 1ps

module bdcb_out_stage
  import bdcb_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  logic    done,
  input  result_t res,
  output logic    rdy,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res,
  output logic    out_last
);

  logic    hold_v_r, hold_v_nxt;
  result_t hold_r;
  logic    out_v_r, out_v_nxt;
  result_t out_r;
  logic    last_r;
  logic    load_out;

  assign rdy      = !hold_v_r || !out_v_r || out_ready;
  assign load_out = (push || done) && hold_v_r && rdy;

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (push && rdy) begin
      hold_v_nxt = 1'b1;
    end else if (done && rdy) begin
      hold_v_nxt = 1'b0;
    end
    if (load_out) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && rdy) begin
      hold_r <= res;
    end
    if (load_out) begin
      out_r  <= hold_r;
      last_r <= done;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;
  assign out_last  = last_r;

endmodule

// ----- rtl/bdcb_ctrl.sv -----
// Sequencer: queue, batch timer, circuit breaker and slot read-modify-write.
`timescale 1ns / 1ps

module bdcb_ctrl
  import bdcb_pkg::*;
#(
  parameter int SLOTS     = DELIVERY_SLOTS_DEF,
  parameter int QUEUE_MAX = QUEUE_MAX_DEF,
  parameter int AW        = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [2:0]         in_slot,
  input  logic               in_ok,
  output logic               push,
  output logic               done,
  output result_t            res,
  input  logic               stage_rdy,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [ENTRY_W-1:0] mem_wdata,
  input  logic [ENTRY_W-1:0] mem_rdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TICK  = 3'd1;
  localparam logic [2:0] ST_TBAT  = 3'd2;
  localparam logic [2:0] ST_CAP   = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;
  localparam logic [2:0] ST_OMOD  = 3'd5;
  localparam logic [2:0] ST_STRAY = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  localparam logic [AW-1:0]    LAST_SLOT = AW'(SLOTS - 1);
  localparam logic [CNT_W-1:0] QMAX_C    = CNT_W'(QUEUE_MAX);

  logic [2:0]         state_r, state_nxt;
  logic [10:0]        batch_size_r, batch_size_nxt;
  logic [10:0]        queue_limit_r, queue_limit_nxt;
  logic [15:0]        batch_delay_r, batch_delay_nxt;
  logic [3:0]         max_att_r, max_att_nxt;
  logic [11:0]        retry_base_r, retry_base_nxt;
  logic [7:0]         fail_thr_r, fail_thr_nxt;
  logic [19:0]        cooldown_r, cooldown_nxt;
  logic [CNT_W-1:0]   queued_r, queued_nxt;
  logic [15:0]        btimer_r, btimer_nxt;
  logic               armed_r, armed_nxt;
  logic [7:0]         fail_cnt_r, fail_cnt_nxt;
  logic               tripped_r, tripped_nxt;
  logic [19:0]        cool_left_r, cool_left_nxt;
  logic               probe_r, probe_nxt;
  logic [SLOTS-1:0]   busy_r, busy_nxt;
  logic [AW-1:0]      s_r, s_nxt;
  logic [2:0]         slot_r;
  logic               ok_r;

  slot_entry_t        ent, wr_ent;
  logic               free_found;
  logic [AW-1:0]      free_idx;
  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   q_inc;
  logic [7:0]         fail_inc;
  logic               in_range;
  logic [AW-1:0]      in_idx;
  logic               need_fire;

  function automatic logic [TIMER_W-1:0] retry_delay(input logic [11:0] base,
                                                     input logic [3:0] att);
    logic [3:0]         sh;
    logic [TIMER_W-1:0] d;
    sh = (att == 4'd0) ? 4'd0 : att - 4'd1;
    d  = TIMER_W'(base) << sh;
    return (d == '0) ? TIMER_W'(1) : d;
  endfunction

  function automatic logic [1:0] mode_of(input logic tripped, input logic [19:0] left);
    if (!tripped) begin
      return MODE_CLOSED;
    end
    return (left != '0) ? MODE_OPEN : MODE_HALF_OPEN;
  endfunction

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  assign ent       = slot_entry_t'(mem_rdata);
  assign limit     = (32'(queue_limit_r) > QUEUE_MAX) ? QMAX_C : queue_limit_r;
  assign q_inc     = queued_r + CNT_W'(1);
  assign fail_inc  = (fail_cnt_r != 8'hFF) ? fail_cnt_r + 8'd1 : fail_cnt_r;
  assign in_range  = 32'(in_slot) < SLOTS;
  assign in_idx    = AW'(in_slot);
  assign need_fire = busy_r[s_r] && ent.retry && (ent.timer <= TIMER_W'(1));
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    batch_size_nxt  = batch_size_r;
    queue_limit_nxt = queue_limit_r;
    batch_delay_nxt = batch_delay_r;
    max_att_nxt     = max_att_r;
    retry_base_nxt  = retry_base_r;
    fail_thr_nxt    = fail_thr_r;
    cooldown_nxt    = cooldown_r;
    queued_nxt      = queued_r;
    btimer_nxt      = btimer_r;
    armed_nxt       = armed_r;
    fail_cnt_nxt    = fail_cnt_r;
    tripped_nxt     = tripped_r;
    cool_left_nxt   = cool_left_r;
    probe_nxt       = probe_r;
    busy_nxt        = busy_r;
    s_nxt           = s_r;
    push            = 1'b0;
    done            = 1'b0;
    res             = '0;
    mem_re          = 1'b0;
    mem_raddr       = s_r;
    mem_we          = 1'b0;
    mem_waddr       = s_r;
    wr_ent          = ent;

    case (state_r)
      ST_IDLE: begin
        if (cfg_we) begin
          case (cfg_index)
            REG_BATCH_SIZE:   batch_size_nxt  = cfg_data[10:0];
            REG_QUEUE_LIMIT:  queue_limit_nxt = cfg_data[10:0];
            REG_BATCH_DELAY:  batch_delay_nxt = cfg_data[15:0];
            REG_MAX_ATTEMPTS: max_att_nxt     = cfg_data[3:0];
            REG_RETRY_BASE:   retry_base_nxt  = cfg_data[11:0];
            REG_FAIL_THRESH:  fail_thr_nxt    = cfg_data[7:0];
            REG_COOLDOWN:     cooldown_nxt    = cfg_data[19:0];
            default: ;
          endcase
        end
        if (in_valid) begin
          case (in_cmd)
            CMD_TICK: begin
              if (cool_left_r != '0) begin
                cool_left_nxt = cool_left_r - 20'd1;
              end
              mem_re    = 1'b1;
              mem_raddr = '0;
              s_nxt     = '0;
              state_nxt = ST_TICK;
            end
            CMD_CAPTURE: state_nxt = ST_CAP;
            CMD_FLUSH:   state_nxt = ST_FLUSH;
            default: begin
              if (in_range && busy_r[in_idx]) begin
                mem_re    = 1'b1;
                mem_raddr = in_idx;
                s_nxt     = in_idx;
                state_nxt = ST_OMOD;
              end else begin
                state_nxt = ST_STRAY;
              end
            end
          endcase
        end
      end

      ST_TICK: begin
        if (!need_fire || stage_rdy) begin
          if (need_fire) begin
            wr_ent.retry = 1'b0;
            wr_ent.timer = '0;
            if (ent.attempt != 4'hF) begin
              wr_ent.attempt = ent.attempt + 4'd1;
            end
            mem_we      = 1'b1;
            push        = 1'b1;
            res.kind    = KIND_RESEND;
            res.slot    = 3'(s_r);
            res.count   = ent.count;
            res.attempt = wr_ent.attempt;
          end else if (busy_r[s_r] && ent.retry) begin
            wr_ent.timer = ent.timer - TIMER_W'(1);
            mem_we       = 1'b1;
          end
          if (s_r == LAST_SLOT) begin
            state_nxt = ST_TBAT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = s_r + AW'(1);
            s_nxt     = s_r + AW'(1);
          end
        end
      end

      ST_TBAT: begin
        if (armed_r && (btimer_r <= 16'd1)) begin
          state_nxt = ST_FLUSH;
        end else begin
          if (armed_r) begin
            btimer_nxt = btimer_r - 16'd1;
          end
          state_nxt = ST_DONE;
        end
      end

      ST_CAP: begin
        if (stage_rdy) begin
          push      = 1'b1;
          state_nxt = ST_DONE;
          if (queued_r >= limit) begin
            res.kind = KIND_DROP_FULL;
          end else begin
            res.kind   = KIND_QUEUED;
            queued_nxt = q_inc;
            if (q_inc >= batch_size_r) begin
              state_nxt = ST_FLUSH;
            end else if (!armed_r) begin
              armed_nxt  = 1'b1;
              btimer_nxt = batch_delay_r;
            end
          end
        end
      end

      ST_FLUSH: begin
        if (queued_r == '0 || stage_rdy) begin
          armed_nxt  = 1'b0;
          btimer_nxt = '0;
          queued_nxt = '0;
          state_nxt  = ST_DONE;
          res.count  = queued_r;
          if (queued_r != '0) begin
            push = 1'b1;
            if (tripped_r && (cool_left_r != '0 || probe_r)) begin
              res.kind = KIND_DROP_CIRCUIT;
            end else if (!free_found) begin
              res.kind = KIND_NO_SLOT;
            end else begin
              if (tripped_r) begin
                probe_nxt = 1'b1;
              end
              busy_nxt[free_idx] = 1'b1;
              wr_ent.retry   = 1'b0;
              wr_ent.attempt = 4'd1;
              wr_ent.count   = queued_r;
              wr_ent.timer   = '0;
              mem_we         = 1'b1;
              mem_waddr      = free_idx;
              res.kind       = KIND_SEND;
              res.slot       = 3'(free_idx);
              res.attempt    = 4'd1;
            end
          end
        end
      end

      ST_OMOD: begin
        if (stage_rdy) begin
          push      = 1'b1;
          state_nxt = ST_DONE;
          res.slot  = slot_r;
          if (ent.retry) begin
            res.kind = KIND_NO_SLOT;
          end else if (ok_r) begin
            fail_cnt_nxt  = '0;
            tripped_nxt   = 1'b0;
            cool_left_nxt = '0;
            probe_nxt     = 1'b0;
            busy_nxt[s_r] = 1'b0;
            res.kind      = KIND_SUCCEEDED;
            res.count     = ent.count;
            res.attempt   = ent.attempt;
          end else if (ent.attempt < max_att_r) begin
            wr_ent.retry = 1'b1;
            wr_ent.timer = retry_delay(retry_base_r, ent.attempt);
            mem_we       = 1'b1;
            res.kind     = KIND_RETRY_SCHED;
            res.count    = ent.count;
            res.attempt  = ent.attempt + 4'd1;
          end else begin
            fail_cnt_nxt = fail_inc;
            if (fail_inc >= fail_thr_r) begin
              tripped_nxt   = 1'b1;
              cool_left_nxt = cooldown_r;
              probe_nxt     = 1'b0;
            end
            busy_nxt[s_r] = 1'b0;
            res.kind      = KIND_GAVE_UP;
            res.count     = ent.count;
            res.attempt   = ent.attempt;
          end
        end
      end

      ST_STRAY: begin
        if (stage_rdy) begin
          push      = 1'b1;
          res.kind  = KIND_NO_SLOT;
          res.slot  = slot_r;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        done = 1'b1;
        if (stage_rdy) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    res.depth = queued_nxt;
    res.mode  = mode_of(tripped_nxt, cool_left_nxt);
  end

  assign mem_wdata = wr_ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      batch_size_r  <= BATCH_SIZE_RST;
      queue_limit_r <= QUEUE_LIMIT_RST;
      batch_delay_r <= BATCH_DELAY_RST;
      max_att_r     <= MAX_ATTEMPTS_RST;
      retry_base_r  <= RETRY_BASE_RST;
      fail_thr_r    <= FAIL_THRESH_RST;
      cooldown_r    <= COOLDOWN_RST;
      queued_r      <= '0;
      btimer_r      <= '0;
      armed_r       <= 1'b0;
      fail_cnt_r    <= '0;
      tripped_r     <= 1'b0;
      cool_left_r   <= '0;
      probe_r       <= 1'b0;
      busy_r        <= '0;
      s_r           <= '0;
    end else begin
      state_r       <= state_nxt;
      batch_size_r  <= batch_size_nxt;
      queue_limit_r <= queue_limit_nxt;
      batch_delay_r <= batch_delay_nxt;
      max_att_r     <= max_att_nxt;
      retry_base_r  <= retry_base_nxt;
      fail_thr_r    <= fail_thr_nxt;
      cooldown_r    <= cooldown_nxt;
      queued_r      <= queued_nxt;
      btimer_r      <= btimer_nxt;
      armed_r       <= armed_nxt;
      fail_cnt_r    <= fail_cnt_nxt;
      tripped_r     <= tripped_nxt;
      cool_left_r   <= cool_left_nxt;
      probe_r       <= probe_nxt;
      busy_r        <= busy_nxt;
      s_r           <= s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slot_r <= in_slot;
      ok_r   <= in_ok;
    end
  end

endmodule

// ----- rtl/batched_delivery_circuit_breaker.sv -----
// Top level: batched report delivery with circuit breaker and retry backoff.
`timescale 1ns / 1ps

// One input word at a time. A tick reads, ages and writes back each delivery
// slot through the slot memory at one slot per cycle while no resend waits on
// a stalled output, then steps the batch timer and flushes when it fires. A
// result word that waits on a stalled output holds the sequencer. The output
// register holds the last result while the next input word is accepted. Slot
// free/busy flags reset at once, so no clearing pass follows reset.
// Configuration writes are taken only between input words.
module batched_delivery_circuit_breaker
  import bdcb_pkg::*;
#(
  parameter int DELIVERY_SLOTS = DELIVERY_SLOTS_DEF,
  parameter int QUEUE_MAX      = QUEUE_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,  // command[1:0], slot[4:2], delivery_ok[5]
  output logic             out_tvalid,
  input  logic             out_tready,
  // out_slot[2:0], batch_count[13:3], attempt_number[17:14],
  // queue_depth[28:18], circuit_mode[30:29]
  output logic [31:0]      out_tdata,
  output logic [3:0]       out_tuser, // kind[3:0]
  output logic             out_tlast
);

  localparam int AW = (DELIVERY_SLOTS > 1) ? $clog2(DELIVERY_SLOTS) : 1;

  logic               push, done, stage_rdy;
  result_t            res, out_res;
  logic               mem_re, mem_we;
  logic [AW-1:0]      mem_raddr, mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

  bdcb_ctrl #(
    .SLOTS     (DELIVERY_SLOTS),
    .QUEUE_MAX (QUEUE_MAX),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tdata[1:0]),
    .in_slot   (in_tdata[4:2]),
    .in_ok     (in_tdata[5]),
    .push      (push),
    .done      (done),
    .res       (res),
    .stage_rdy (stage_rdy),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  bdcb_slot_mem #(
    .SLOTS (DELIVERY_SLOTS),
    .AW    (AW)
  ) u_slot_mem (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  bdcb_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .done      (done),
    .res       (res),
    .rdy       (stage_rdy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res),
    .out_last  (out_tlast)
  );

  assign out_tuser = out_res.kind;
  assign out_tdata = {1'b0, out_res.mode, out_res.depth, out_res.attempt,
                      out_res.count, out_res.slot};

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in flight");

  a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (done && stage_rdy) |=> in_tready)
    else $error("sequencer did not return to idle after last word");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("slot memory read and write hit the same entry");

  a_no_push_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !push)
    else $error("result pushed in the end-of-item cycle");
`endif

endmodule
